@@ hw/rtl/fcsg_pkg.sv @@
// ---------------------------------------------------------------------------
// fcsg_pkg
// Shared constants and controller/datapath interface types for the
// filled-circle span generator.
// ---------------------------------------------------------------------------
`default_nettype none

package fcsg_pkg;

  localparam int unsigned MAX_RADIUS_DEF = 64;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned COLOUR_W = 16;
  localparam int unsigned RADIUS_W = 7;
  localparam int unsigned COUNT_W  = 8;

  // slave word: centre_x, centre_y, radius, fill_colour, zero pad
  localparam int unsigned IN_DATA_W  = 56;
  // master word: x_start, x_end, row_above, row_below, pixel_count, colour
  localparam int unsigned OUT_DATA_W = 88;

  localparam int unsigned CX_LSB  = 0;
  localparam int unsigned CY_LSB  = 16;
  localparam int unsigned RAD_LSB = 32;
  localparam int unsigned COL_LSB = 39;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch command fields
    logic init_lim;  // lim = r*r
    logic init_yy;   // yy = (r-1)^2
    logic step_x;    // x = x+1
    logic emit;      // load output register
    logic next_row;  // y = y-1
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cmd_zero;  // incoming radius is zero
    logic can_grow;  // (x+1)^2 + y^2 <= r^2 and x < r
    logic last_row;  // y == 0
    logic out_free;  // output register can take a word
  } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/fcsg_dp.sv @@
// ---------------------------------------------------------------------------
// fcsg_dp
// Datapath: command registers, incremental x/y square tracking and the
// output word register.
// ---------------------------------------------------------------------------
`default_nettype none

module fcsg_dp #(
  parameter int unsigned MAX_RADIUS = fcsg_pkg::MAX_RADIUS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [fcsg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  wire fcsg_pkg::cmd_t                  cmd,
  output fcsg_pkg::status_t                    status,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [fcsg_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tlast
);

  localparam int unsigned RW  = $clog2(MAX_RADIUS + 1);
  localparam int unsigned SQW = $clog2(2 * (MAX_RADIUS + 1) * (MAX_RADIUS + 1));

  logic [fcsg_pkg::COORD_W-1:0]  cx, cy;
  logic [fcsg_pkg::COLOUR_W-1:0] col;
  logic [RW-1:0]                 rad, x, y;
  logic [SQW-1:0]                lim, xs1, yy;

  logic [fcsg_pkg::RADIUS_W-1:0] radius_in;
  logic [RW-1:0]                 rad_sat;
  logic [SQW-1:0]                probe;

  logic [fcsg_pkg::COORD_W-1:0]  x_start, x_end, row_above, row_below;
  logic [fcsg_pkg::COUNT_W-1:0]  pix_cnt;
  logic [fcsg_pkg::COLOUR_W-1:0] out_col;
  logic                          out_last;

  assign radius_in = s_axis_tdata[fcsg_pkg::RAD_LSB +: fcsg_pkg::RADIUS_W];
  assign rad_sat   = (radius_in > fcsg_pkg::RADIUS_W'(MAX_RADIUS)) ?
                     RW'(MAX_RADIUS) : RW'(radius_in);
  assign probe     = xs1 + yy;

  assign status.cmd_zero = (radius_in == '0);
  assign status.can_grow = (x < rad) && (probe <= lim);
  assign status.last_row = (y == '0);
  assign status.out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx  <= s_axis_tdata[fcsg_pkg::CX_LSB +: fcsg_pkg::COORD_W];
      cy  <= s_axis_tdata[fcsg_pkg::CY_LSB +: fcsg_pkg::COORD_W];
      col <= s_axis_tdata[fcsg_pkg::COL_LSB +: fcsg_pkg::COLOUR_W];
      rad <= rad_sat;
      x   <= RW'(1);
      xs1 <= SQW'(4);
      y   <= rad_sat - RW'(1);
    end
    if (cmd.init_lim) begin
      lim <= SQW'(rad) * SQW'(rad);
    end
    if (cmd.init_yy) begin
      // (r-1)^2 = r^2 - 2r + 1
      yy <= lim - (SQW'(rad) << 1) + SQW'(1);
    end
    if (cmd.step_x) begin
      // (x+2)^2 - (x+1)^2 = 2x + 3
      x   <= x + RW'(1);
      xs1 <= xs1 + (SQW'(x) << 1) + SQW'(3);
    end
    if (cmd.next_row) begin
      // y^2 - (y-1)^2 = 2y - 1
      y  <= y - RW'(1);
      yy <= yy - ((SQW'(y) << 1) - SQW'(1));
    end
    if (cmd.emit) begin
      x_start   <= cx - fcsg_pkg::COORD_W'(x);
      x_end     <= cx + fcsg_pkg::COORD_W'(x) - fcsg_pkg::COORD_W'(1);
      row_above <= cy - fcsg_pkg::COORD_W'(y);
      row_below <= cy + fcsg_pkg::COORD_W'(y);
      pix_cnt   <= fcsg_pkg::COUNT_W'({x, 1'b0});
      out_col   <= col;
      out_last  <= (y == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {out_col, pix_cnt, row_below, row_above, x_end, x_start};
  assign m_axis_tlast = out_last;

endmodule

`default_nettype wire

@@ hw/rtl/fcsg_ctrl.sv @@
// ---------------------------------------------------------------------------
// fcsg_ctrl
// Controller: takes a command, sequences setup, the x search and the
// per-row word emission.
// ---------------------------------------------------------------------------
`default_nettype none

module fcsg_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire fcsg_pkg::status_t  status,
  output fcsg_pkg::cmd_t          cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LIM    = 2'd1;
  localparam logic [1:0] ST_YY     = 2'd2;
  localparam logic [1:0] ST_SEARCH = 2'd3;

  logic [1:0] state, state_next;

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.load = 1'b1;
          if (!status.cmd_zero) begin
            state_next = ST_LIM;
          end
        end
      end
      ST_LIM: begin
        cmd.init_lim = 1'b1;
        state_next   = ST_YY;
      end
      ST_YY: begin
        cmd.init_yy = 1'b1;
        state_next  = ST_SEARCH;
      end
      ST_SEARCH: begin
        priority if (status.can_grow) begin
          cmd.step_x = 1'b1;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_row) begin
            state_next = ST_IDLE;
          end else begin
            cmd.next_row = 1'b1;
          end
        end else begin
          state_next = ST_SEARCH;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/filled_circle_span_generator_top.sv @@
// ---------------------------------------------------------------------------
// filled_circle_span_generator_top
// Filled-circle rasterizer: one command word in, one span word per row
// offset out.
// ---------------------------------------------------------------------------
// A command (centre, radius, colour) yields r span words, r being the radius
// clipped to MAX_RADIUS, for row offsets y = r-1 down to 0; radius zero yields
// nothing. Each word carries the columns centre_x-x .. centre_x+x-1, where x
// is the widest half-width with x*x + y*y <= r*r, the two rows centre_y-y and
// centre_y+y, the pixel count 2x and the colour; tlast marks the centre row,
// whose two rows coincide. All coordinates wrap modulo 2^16. A command first
// sets up r*r and then (r-1)^2, then runs the search loop sequenced by the
// controller, which either increments x or emits the current row once the
// output register can take a word. x only grows as y falls, so its squares
// are tracked by adds. The slave side takes a new command only once the last
// word of the previous one has been placed in the output register; that
// register lets the search continue while a finished word waits on the
// master side.
// ---------------------------------------------------------------------------
`default_nettype none

module filled_circle_span_generator_top #(
  parameter int unsigned MAX_RADIUS = fcsg_pkg::MAX_RADIUS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // command word
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] centre_x, [31:16] centre_y, [38:32] radius, [54:39] fill_colour
  input  wire logic [fcsg_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // span word
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [15:0] span_x_start, [31:16] span_x_end, [47:32] row_above,
  // [63:48] row_below, [71:64] pixel_count, [87:72] span_colour
  output logic [fcsg_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast  // last_span
);

  fcsg_pkg::cmd_t    cmd;
  fcsg_pkg::status_t status;

  fcsg_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  fcsg_dp #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .cmd           (cmd),
    .status        (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // no search or emit while a new command may be taken
  a_busy_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && (cmd.step_x || cmd.emit || cmd.next_row)))
    else $error("datapath stepped while idle");

  // an emitted word shows up on the master side next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_axis_tvalid)
    else $error("emitted word not presented");

  // every span covers at least two pixels
  a_count_nz: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[71:64] != 8'd0))
    else $error("zero pixel count");

  // centre row word has both rows equal
  a_last_rows: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[47:32] == m_axis_tdata[63:48]))
    else $error("last span rows differ");

endmodule

`default_nettype wire
